>>> hdl/sequential_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list engine package
// Shared types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int POS_W        = 8;
	localparam int WORD_W       = 32;
	localparam int COUNT_W      = 8;
	localparam int FOUND_W      = 8;

	localparam logic signed [FOUND_W-1:0] FOUND_NONE = -8'sd1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_GET    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		op_t                      op;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [WORD_W-1:0]  data;
		logic signed [FOUND_W-1:0] found_index;
		logic [COUNT_W-1:0]        count;
		logic                      empty_res;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    item_load;    // capture request
		logic    idx_from_len; // index <= length - 1
		logic    idx_from_pos; // index <= position - 1
		logic    idx_zero;     // index <= 0
		logic    idx_inc;
		logic    idx_dec;
		logic    mem_rd;       // read entry at index
		logic    wr_shift;     // write last read word one slot up
		logic    wr_value;     // write request value at position
		logic    len_inc;
		logic    len_clear;
		logic    note_en;      // record result kind
		status_t note_status;
		logic    note_data;    // result carries read word
		logic    note_found;   // result carries read address
		logic    res_load;     // load output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		op_t  op;
		logic ins_bad;    // insert slot above length
		logic full;
		logic pos_eq_len;
		logic get_bad;    // get slot zero or above length
		logic idx_lt_len;
		logic rd_vld;     // read data register holds a fresh word
		logic shift_last; // fresh word came from the insert slot
		logic match;      // fresh word equals request value
		logic res_free;   // output register can take a result
	} stat_t;

endpackage

>>> hdl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// Sequential list engine
// Bounded ordered list of signed words with insert, get, search and clear.
// ----------------------------------------------------------------------------
// One request is worked at a time; a new request transfer is taken once the
// previous one has placed its result in the output register, even while that
// result is still stalled. An insert at slot p into a list of n words moves
// n-p words up one slot per cycle through the memory, one read and one write
// each cycle, when p is below n, and moves none when p equals n; a search
// compares one entry per cycle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sle_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sle_pkg::rsp_t rsp
);
	import sle_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  idle;

	assign req_stall = !idle;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.idle      (idle),
		.st        (st),
		.cmd       (cmd)
	);

	sle_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> hdl/sle_dp.sv
// ----------------------------------------------------------------------------
// Sequential list engine datapath
// Entry memory, length and index registers, request capture and the
// registered output stage.
// ----------------------------------------------------------------------------
`include "sequential_list_engine_assert.svh"

module sle_dp #(
	parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  sle_pkg::req_t req,
	input  sle_pkg::cmd_t cmd,
	output sle_pkg::stat_t st,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output sle_pkg::rsp_t rsp
);
	import sle_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	// Entry storage
	logic [WORD_W-1:0] mem [CAPACITY];

	logic [LW-1:0]     len_q;
	logic [LW-1:0]     idx_q;
	op_t               op_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] value_q;

	logic [WORD_W-1:0] rdata_s1;
	logic [AW-1:0]     rd_addr_s1;
	logic              rd_vld_s1;

	status_t           note_status_q;
	logic              note_data_q;
	logic              note_found_q;

	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// Common-width compare operands, address arithmetic and widened result fields
	logic [CW+LW-1:0]    len_x;
	logic [CW+POS_W-1:0] pos_x;
	logic [CW-1:0]       len_w;
	logic [CW-1:0]       pos_w;
	logic [CW-1:0]       pos_m1;
	logic [LW-1:0]       len_m1;
	logic [AW-1:0]       wr_addr;
	logic [LW+COUNT_W-1:0] cnt_x;
	logic [AW+FOUND_W-1:0] fnd_x;

	assign len_x   = {{CW{1'b0}}, len_q};
	assign pos_x   = {{CW{1'b0}}, pos_q};
	assign len_w   = len_x[CW-1:0];
	assign pos_w   = pos_x[CW-1:0];
	assign pos_m1  = pos_w - CW'(1);
	assign len_m1  = len_q - LW'(1);
	assign wr_addr = cmd.wr_value ? pos_w[AW-1:0] : (rd_addr_s1 + AW'(1));
	assign cnt_x   = {{COUNT_W{1'b0}}, len_q};
	assign fnd_x   = {{FOUND_W{1'b0}}, rd_addr_s1};

	// Status toward the controller
	always_comb begin
		st.op         = op_q;
		st.ins_bad    = pos_w > len_w;
		st.full       = len_q == LW'(CAPACITY);
		st.pos_eq_len = pos_w == len_w;
		st.get_bad    = (pos_w == '0) || (pos_w > len_w);
		st.idx_lt_len = idx_q < len_q;
		st.rd_vld     = rd_vld_s1;
		st.shift_last = rd_vld_s1 && (rd_addr_s1 == pos_w[AW-1:0]);
		st.match      = rd_vld_s1 && (rdata_s1 == value_q);
		st.res_free   = !rsp_valid_q || !rsp_stall;
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_shift || cmd.wr_value) begin
			mem[wr_addr] <= cmd.wr_value ? value_q : rdata_s1;
		end
		if (cmd.mem_rd) begin
			rdata_s1   <= mem[idx_q[AW-1:0]];
			rd_addr_s1 <= idx_q[AW-1:0];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.mem_rd;
			if (cmd.len_clear) begin
				len_q <= '0;
			end else if (cmd.len_inc) begin
				len_q <= len_q + LW'(1);
			end
			priority if (cmd.idx_from_len) begin
				idx_q <= len_m1;
			end else if (cmd.idx_from_pos) begin
				idx_q <= pos_m1[LW-1:0];
			end else if (cmd.idx_zero) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + LW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - LW'(1);
			end
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, result kind, output payload
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			op_q    <= req.op;
			pos_q   <= req.position;
			value_q <= req.value;
		end
		if (cmd.note_en) begin
			note_status_q <= cmd.note_status;
			note_data_q   <= cmd.note_data;
			note_found_q  <= cmd.note_found;
		end
		if (cmd.res_load) begin
			rsp_q.status      <= note_status_q;
			rsp_q.data        <= note_data_q ? rdata_s1 : '0;
			rsp_q.found_index <= note_found_q ? fnd_x[FOUND_W-1:0] : FOUND_NONE;
			rsp_q.count       <= cnt_x[COUNT_W-1:0];
			rsp_q.empty_res   <= len_q == '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SLE_ASSERT_IMP(a_len_bound, 1'b1, len_q <= LW'(CAPACITY), "list length above capacity")
	`SLE_ASSERT_IMP(a_res_no_overwrite, cmd.res_load, !rsp_valid_q || !rsp_stall,
		"result loaded over a stalled result")
	`SLE_ASSERT_IMP(a_one_write, cmd.wr_shift, !cmd.wr_value, "two memory writes in one cycle")
	`SLE_ASSERT_NXT(a_clear_len, cmd.len_clear, len_q == '0, "clear left a nonzero length")

endmodule

>>> hdl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// Sequential list engine controller
// One-hot state machine that sequences insert shifts, reads, searches and
// result delivery through datapath commands.
// ----------------------------------------------------------------------------
`include "sequential_list_engine_assert.svh"

module sle_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          idle,
	input  sle_pkg::stat_t st,
	output sle_pkg::cmd_t  cmd
);
	import sle_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DISPATCH = 8'b0000_0010,
		S_SHIFT    = 8'b0000_0100,
		S_WRITE    = 8'b0000_1000,
		S_GET_RD   = 8'b0001_0000,
		S_GET_WAIT = 8'b0010_0000,
		S_SEARCH   = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign idle = state_q == S_IDLE;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (st.op)
					OP_INSERT: begin
						priority if (st.ins_bad) begin
							cmd.note_en     = 1'b1;
							cmd.note_status = ST_BADPOS;
							state_d         = S_DONE;
						end else if (st.full) begin
							cmd.note_en     = 1'b1;
							cmd.note_status = ST_FULL;
							state_d         = S_DONE;
						end else if (st.pos_eq_len) begin
							state_d = S_WRITE;
						end else begin
							cmd.idx_from_len = 1'b1;
							state_d          = S_SHIFT;
						end
					end
					OP_GET: begin
						if (st.get_bad) begin
							cmd.note_en     = 1'b1;
							cmd.note_status = ST_BADPOS;
							state_d         = S_DONE;
						end else begin
							cmd.idx_from_pos = 1'b1;
							state_d          = S_GET_RD;
						end
					end
					OP_SEARCH: begin
						cmd.idx_zero = 1'b1;
						state_d      = S_SEARCH;
					end
					OP_CLEAR: begin
						cmd.len_clear   = 1'b1;
						cmd.note_en     = 1'b1;
						cmd.note_status = ST_OK;
						state_d         = S_DONE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			// Walk down from the top entry, moving each word up one slot
			S_SHIFT: begin
				cmd.wr_shift = st.rd_vld;
				if (st.shift_last) begin
					state_d = S_WRITE;
				end else begin
					cmd.mem_rd  = 1'b1;
					cmd.idx_dec = 1'b1;
				end
			end
			S_WRITE: begin
				cmd.wr_value    = 1'b1;
				cmd.len_inc     = 1'b1;
				cmd.note_en     = 1'b1;
				cmd.note_status = ST_OK;
				state_d         = S_DONE;
			end
			S_GET_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_GET_WAIT;
			end
			S_GET_WAIT: begin
				cmd.note_en     = 1'b1;
				cmd.note_status = ST_OK;
				cmd.note_data   = 1'b1;
				state_d         = S_DONE;
			end
			// Reads issue one per cycle; each compare works on the registered read data
			S_SEARCH: begin
				priority if (st.match) begin
					cmd.note_en     = 1'b1;
					cmd.note_status = ST_OK;
					cmd.note_found  = 1'b1;
					state_d         = S_DONE;
				end else if (st.idx_lt_len) begin
					cmd.mem_rd  = 1'b1;
					cmd.idx_inc = 1'b1;
				end else if (!st.rd_vld) begin
					cmd.note_en     = 1'b1;
					cmd.note_status = ST_OK;
					state_d         = S_DONE;
				end
			end
			S_DONE: begin
				if (st.res_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SLE_ASSERT_NXT(a_accept_dispatch, req_valid && idle, state_q == S_DISPATCH,
		"accepted transfer did not reach dispatch")
	`SLE_ASSERT_IMP(a_load_only_idle, cmd.item_load, state_q == S_IDLE,
		"request captured outside idle")

endmodule

>>> dv/tb_sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Drives a short directed table, then fill-to-capacity runs and random
// traffic through the request channel. A shadow copy of the list predicts
// every response, and the responses are checked field by field in order.
// The sender and receiver idle at random, except in the last phase.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine;

	import sle_pkg::*;

	localparam int LIST_DEPTH     = CAPACITY_DEF;
	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 11;
	localparam int RAND_PER_PHASE = 160;
	localparam int DRAIN_CYCLES   = LIST_DEPTH + 16;
	localparam int STALL_LIMIT    = 4000;

	// One directed row; rows with pinned set carry their response typed in
	typedef struct {
		req_t req;
		bit   pinned;
		rsp_t rsp;
	} stim_row_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	req_t  req       = '0;
	logic  rsp_stall = 1'b0;
	logic  req_stall;
	logic  rsp_valid;
	rsp_t  rsp;

	// Shadow list state
	logic signed [WORD_W-1:0] list_words [LIST_DEPTH];
	int                       list_len = 0;

	rsp_t      pending_rsps [$];
	stim_row_t fixed_rsps [$];
	int        err_count   = 0;
	int        idle_cycles = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;

	stim_row_t dir_rows [23] = '{
		// empty list after reset
		'{req_t'{OP_GET, 8'd1, 32'h0}, 1'b1, rsp_t'{ST_BADPOS, 32'h0, FOUND_NONE, 8'd0, 1'b1}},
		'{req_t'{OP_GET, 8'd0, 32'h0}, 1'b1, rsp_t'{ST_BADPOS, 32'h0, FOUND_NONE, 8'd0, 1'b1}},
		'{req_t'{OP_SEARCH, 8'd0, 32'h0}, 1'b1, rsp_t'{ST_OK, 32'h0, FOUND_NONE, 8'd0, 1'b1}},
		'{req_t'{OP_INSERT, 8'd1, 32'h5}, 1'b1, rsp_t'{ST_BADPOS, 32'h0, FOUND_NONE, 8'd0, 1'b1}},
		'{req_t'{OP_INSERT, 8'd255, 32'hFFFF_FFFF}, 1'b1,
			rsp_t'{ST_BADPOS, 32'h0, FOUND_NONE, 8'd0, 1'b1}},
		'{req_t'{OP_CLEAR, 8'd255, 32'hFFFF_FFFF}, 1'b1,
			rsp_t'{ST_OK, 32'h0, FOUND_NONE, 8'd0, 1'b1}},
		// extremes, head and tail inserts
		'{req_t'{OP_INSERT, 8'd0, 32'h7FFF_FFFF}, 1'b1,
			rsp_t'{ST_OK, 32'h0, FOUND_NONE, 8'd1, 1'b0}},
		'{req_t'{OP_INSERT, 8'd0, 32'h8000_0000}, 1'b1,
			rsp_t'{ST_OK, 32'h0, FOUND_NONE, 8'd2, 1'b0}},
		'{req_t'{OP_INSERT, 8'd2, 32'hFFFF_FFFF}, 1'b1,
			rsp_t'{ST_OK, 32'h0, FOUND_NONE, 8'd3, 1'b0}},
		'{req_t'{OP_INSERT, 8'd1, 32'h0}, 1'b1, rsp_t'{ST_OK, 32'h0, FOUND_NONE, 8'd4, 1'b0}},
		'{req_t'{OP_GET, 8'd1, 32'h0}, 1'b0, '0},
		'{req_t'{OP_GET, 8'd4, 32'h0}, 1'b0, '0},
		'{req_t'{OP_GET, 8'd5, 32'h0}, 1'b1, rsp_t'{ST_BADPOS, 32'h0, FOUND_NONE, 8'd4, 1'b0}},
		'{req_t'{OP_GET, 8'd0, 32'h0}, 1'b1, rsp_t'{ST_BADPOS, 32'h0, FOUND_NONE, 8'd4, 1'b0}},
		// search ignores position
		'{req_t'{OP_SEARCH, 8'd200, 32'hFFFF_FFFF}, 1'b0, '0},
		'{req_t'{OP_SEARCH, 8'd0, 32'h7FFF_FFFF}, 1'b0, '0},
		'{req_t'{OP_SEARCH, 8'd0, 32'd12345}, 1'b0, '0},
		'{req_t'{OP_INSERT, 8'd6, 32'h1}, 1'b1, rsp_t'{ST_BADPOS, 32'h0, FOUND_NONE, 8'd4, 1'b0}},
		'{req_t'{OP_INSERT, 8'd4, 32'hAAAA_5555}, 1'b0, '0},
		'{req_t'{OP_GET, 8'd5, 32'h0}, 1'b0, '0},
		'{req_t'{OP_CLEAR, 8'd0, 32'h0}, 1'b1, rsp_t'{ST_OK, 32'h0, FOUND_NONE, 8'd0, 1'b1}},
		'{req_t'{OP_GET, 8'd1, 32'h0}, 1'b1, rsp_t'{ST_BADPOS, 32'h0, FOUND_NONE, 8'd0, 1'b1}},
		// stale words past the length must not match
		'{req_t'{OP_SEARCH, 8'd0, 32'hAAAA_5555}, 1'b1,
			rsp_t'{ST_OK, 32'h0, FOUND_NONE, 8'd0, 1'b1}}
	};

	sequential_list_engine #(
		.CAPACITY(LIST_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Apply one request to the shadow list and return its response
	function automatic rsp_t apply_list_op(req_t r);
		rsp_t res;
		int   k;
		bit   hit;
		res.status      = ST_OK;
		res.data        = '0;
		res.found_index = FOUND_NONE;
		hit             = 1'b0;
		case (r.op)
			OP_INSERT: begin
				if (int'(r.position) > list_len) begin
					res.status = ST_BADPOS;
				end else if (list_len >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (k = list_len; k > int'(r.position); k--)
						list_words[k] = list_words[k-1];
					list_words[r.position] = r.value;
					list_len++;
				end
			end
			OP_GET: begin
				if (r.position == 0 || int'(r.position) > list_len)
					res.status = ST_BADPOS;
				else
					res.data = list_words[r.position - 1];
			end
			OP_SEARCH: begin
				for (k = 0; k < list_len && !hit; k++) begin
					if (list_words[k] == r.value) begin
						res.found_index = FOUND_W'(k);
						hit = 1'b1;
					end
				end
			end
			default: begin
				list_len = 0;
			end
		endcase
		res.count     = COUNT_W'(list_len);
		res.empty_res = (list_len == 0);
		return res;
	endfunction

	// Word to insert or search for: a stored one or a fresh one, extremes often
	function automatic logic signed [WORD_W-1:0] pick_word(bit reuse);
		logic signed [WORD_W-1:0] w;
		if (reuse && list_len > 0) begin
			w = list_words[$urandom_range(0, list_len - 1)];
		end else begin
			case ($urandom_range(0, 7))
				0:       w = 32'h8000_0000;
				1:       w = 32'h7FFF_FFFF;
				2:       w = 32'h0;
				3:       w = 32'hFFFF_FFFF;
				default: w = $urandom;
			endcase
		end
		return w;
	endfunction

	// Mostly legal requests against the current list, some noise
	function automatic req_t rand_req();
		req_t        r;
		int unsigned pick;
		pick       = $urandom_range(0, 99);
		r.value    = pick_word($urandom_range(0, 3) == 0);
		r.position = POS_W'($urandom_range(0, 255));
		if (pick < 45) begin
			r.op       = OP_INSERT;
			r.position = POS_W'($urandom_range(0, list_len));
		end else if (pick < 65) begin
			r.op = OP_GET;
			if (list_len > 0)
				r.position = POS_W'($urandom_range(1, list_len));
		end else if (pick < 85) begin
			r.op    = OP_SEARCH;
			r.value = pick_word($urandom_range(0, 4) != 0);
		end else if (pick < 87) begin
			r.op = OP_CLEAR;
		end else begin
			r.op    = op_t'($urandom_range(0, 3));
			r.value = $urandom;
		end
		return r;
	endfunction

	// One request transfer; called and returns at a falling edge
	task automatic send_req(input req_t r, input bit pinned, input rsp_t pin_rsp);
		stim_row_t fx;
		fx.req    = r;
		fx.pinned = pinned;
		fx.rsp    = pin_rsp;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		fixed_rsps.push_back(fx);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Fill to capacity, hit the full and bad-slot cases, read and search the top, clear
	task automatic fill_list();
		send_req(req_t'{OP_CLEAR, 8'd0, 32'h0}, 1'b0, '0);
		while (list_len < LIST_DEPTH)
			send_req(req_t'{OP_INSERT, POS_W'($urandom_range(0, list_len)),
				pick_word($urandom_range(0, 7) == 0)}, 1'b0, '0);
		send_req(req_t'{OP_INSERT, POS_W'(LIST_DEPTH), pick_word(1'b0)}, 1'b0, '0);
		send_req(req_t'{OP_INSERT, POS_W'(LIST_DEPTH + 1), pick_word(1'b0)}, 1'b0, '0);
		send_req(req_t'{OP_GET, POS_W'(LIST_DEPTH), 32'h0}, 1'b0, '0);
		send_req(req_t'{OP_GET, POS_W'(LIST_DEPTH + 1), 32'h0}, 1'b0, '0);
		send_req(req_t'{OP_SEARCH, 8'd0, list_words[LIST_DEPTH-1]}, 1'b0, '0);
		send_req(req_t'{OP_SEARCH, 8'd0, pick_word(1'b0)}, 1'b0, '0);
		send_req(req_t'{OP_CLEAR, 8'd0, 32'h0}, 1'b0, '0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			err_count++;
		end
	endtask

	// Receiver stall
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Response check first, then prediction for an accepted request
	always @(posedge clk) begin : monitor
		rsp_t      want;
		stim_row_t fx;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsps.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %h", $time, rsp);
					err_count++;
				end else begin
					want = pending_rsps.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("data", want.data, rsp.data);
					check_field("found_index", want.found_index, rsp.found_index);
					check_field("count", want.count, rsp.count);
					check_field("empty_res", want.empty_res, rsp.empty_res);
				end
			end
			if (req_valid && !req_stall) begin
				fx   = fixed_rsps.pop_front();
				want = apply_list_op(req);
				pending_rsps.push_back(fx.pinned ? fx.rsp : want);
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("tb_sequential_list_engine: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase;
		tx_idle_pct = 23;
		rx_idle_pct = 76;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].rsp);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 23;
					rx_idle_pct = 76;
				end
				1: begin
					tx_idle_pct = 76;
					rx_idle_pct = 23;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			if (phase != 1)
				fill_list();
			repeat (RAND_PER_PHASE)
				send_req(rand_req(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		// Drain, then give stray responses a chance to show up
		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_sequential_list_engine: clean");
		else
			$display("tb_sequential_list_engine: errors");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/sle_pkg.sv
hdl/sle_dp.sv
hdl/sle_ctrl.sv
hdl/sequential_list_engine.sv
dv/tb_sequential_list_engine.sv
